/* rtl/core/llr_pkg.sv */
// llr_pkg: shared types, widths and constants of the log-linear ramp evaluator
// holds the word structs, the pipeline tag, register indexes and the ln(1+f) table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package llr_pkg;

    localparam int DATA_W  = 32;
    localparam int FRAC_W  = 24;
    localparam int POS_W   = $clog2(DATA_W);
    localparam int TAB_W   = 24;
    localparam int SEG_W   = 4;
    localparam int SLOPE_W = 20;
    localparam int REM_W   = DATA_W - 1 - SEG_W;
    localparam int PROD_W  = SLOPE_W + REM_W;
    localparam int EXP_W   = POS_W + 2;
    localparam int LNP_W   = 31;
    localparam int LN_W    = 32;
    localparam int LT_W    = 2 * DATA_W - FRAC_W;
    localparam int BT_W    = 2 * DATA_W + 1 - FRAC_W;
    localparam int SUM_W   = BT_W + 2;
    localparam int IDX_W   = 3;

    localparam logic signed [46:0] LN2_Q40 = 47'sd762123384785;

    // ln(1 + k/16), k = 0..16, unsigned Q0.24
    localparam logic [TAB_W-1:0] LN_TAB [0:16] = '{
        24'd0,       24'd1017112, 24'd1976071, 24'd2883169, 24'd3743728,
        24'd4562291, 24'd5342767, 24'd6088544, 24'd6802576, 24'd7487455,
        24'd8145469, 24'd8778647, 24'd9388795, 24'd9977530, 24'd10546303,
        24'd11096425, 24'd11629080
    };

    typedef enum logic [IDX_W-1:0] {
        REG_LOG_OFFSET    = 3'd0,
        REG_LOG_GAIN      = 3'd1,
        REG_LINEAR_GAIN   = 3'd2,
        REG_CONSTANT_TERM = 3'd3,
        REG_LINEAR_OFFSET = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_x;
        logic                     last_in;
    } in_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] flux;
        logic                     last_out;
    } out_word_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic gt;
    } tag_t;

endpackage

`default_nettype wire

/* rtl/core/log_linear_ramp_model.sv */
// log_linear_ramp_model: top level, coefficient registers and pipeline hookup
// pipeline: eight register stages, the last one being the output register
// throughput: one word per cycle; the whole pipeline holds while the output word waits
// reset: synchronous, active low; clears all stage valid bits and the coefficients to zero
// depends on llr_pkg, llr_front, llr_log, llr_back
`timescale 1ns / 1ps
`default_nettype none

module log_linear_ramp_model (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire llr_pkg::in_word_t                   s_data,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output llr_pkg::out_word_t                       m_data,
    input  wire logic                                cfg_we,
    input  wire logic [llr_pkg::IDX_W-1:0]           cfg_index,
    input  wire logic [llr_pkg::DATA_W-1:0]          cfg_wdata
);

    localparam int W = llr_pkg::DATA_W;

    logic signed [W-1:0] log_offset_reg;
    logic signed [W-1:0] log_gain_reg;
    logic signed [W-1:0] linear_gain_reg;
    logic signed [W-1:0] constant_term_reg;
    logic signed [W-1:0] linear_offset_reg;

    logic                              ce;
    llr_pkg::tag_t                     front_tag;
    logic [W-1:0]                      front_d;
    logic [llr_pkg::POS_W-1:0]         front_p;
    logic signed [llr_pkg::BT_W-1:0]   front_bt;
    llr_pkg::tag_t                     log_tag;
    logic signed [llr_pkg::LN_W-1:0]   log_lnv;
    logic signed [llr_pkg::BT_W-1:0]   log_bt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log_offset_reg    <= '0;
            log_gain_reg      <= '0;
            linear_gain_reg   <= '0;
            constant_term_reg <= '0;
            linear_offset_reg <= '0;
        end else if (cfg_we) begin
            unique case (llr_pkg::cfg_reg_t'(cfg_index))
                llr_pkg::REG_LOG_OFFSET:    log_offset_reg    <= cfg_wdata;
                llr_pkg::REG_LOG_GAIN:      log_gain_reg      <= cfg_wdata;
                llr_pkg::REG_LINEAR_GAIN:   linear_gain_reg   <= cfg_wdata;
                llr_pkg::REG_CONSTANT_TERM: constant_term_reg <= cfg_wdata;
                llr_pkg::REG_LINEAR_OFFSET: linear_offset_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // pipeline advances unless a finished word is held at the output
    assign ce      = !m_valid || m_ready;
    assign s_ready = ce;

    llr_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ce            (ce),
        .in_valid      (s_valid),
        .in_data       (s_data),
        .log_offset    (log_offset_reg),
        .linear_offset (linear_offset_reg),
        .linear_gain   (linear_gain_reg),
        .tag_o         (front_tag),
        .d_o           (front_d),
        .p_o           (front_p),
        .bt_o          (front_bt)
    );

    llr_log u_log (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ce      (ce),
        .tag_i   (front_tag),
        .d_i     (front_d),
        .p_i     (front_p),
        .bt_i    (front_bt),
        .tag_o   (log_tag),
        .lnv_o   (log_lnv),
        .bt_o    (log_bt)
    );

    llr_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ce            (ce),
        .tag_i         (log_tag),
        .lnv_i         (log_lnv),
        .bt_i          (log_bt),
        .log_gain      (log_gain_reg),
        .constant_term (constant_term_reg),
        .out_valid     (m_valid),
        .out_data      (m_data)
    );

endmodule

`default_nettype wire

/* rtl/core/llr_front.sv */
// llr_front: offset subtraction, leading-one search and the linear product
// stages one and two of the pipeline
// depends on llr_pkg
`timescale 1ns / 1ps
`default_nettype none

module llr_front (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                ce,
    input  wire logic                                in_valid,
    input  wire llr_pkg::in_word_t                   in_data,
    input  wire logic signed [llr_pkg::DATA_W-1:0]   log_offset,
    input  wire logic signed [llr_pkg::DATA_W-1:0]   linear_offset,
    input  wire logic signed [llr_pkg::DATA_W-1:0]   linear_gain,
    output llr_pkg::tag_t                            tag_o,
    output logic [llr_pkg::DATA_W-1:0]               d_o,
    output logic [llr_pkg::POS_W-1:0]                p_o,
    output logic signed [llr_pkg::BT_W-1:0]          bt_o
);

    localparam int W = llr_pkg::DATA_W;

    // stage one
    llr_pkg::tag_t          tag1_reg, tag1_next;
    logic signed [W:0]      d1_reg, d1_next;
    logic signed [W:0]      xm1_reg, xm1_next;

    // stage two
    llr_pkg::tag_t                   tag2_reg;
    logic [W-1:0]                    d2_reg;
    logic [llr_pkg::POS_W-1:0]       p2_reg, p2_next;
    logic signed [llr_pkg::BT_W-1:0] bt2_reg, bt2_next;
    logic signed [2*W:0]             lin_prod;

    always_comb begin
        d1_next  = (W+1)'(in_data.sample_x) - (W+1)'(log_offset);
        xm1_next = (W+1)'(in_data.sample_x) - (W+1)'(linear_offset);
        tag1_next.valid = in_valid;
        tag1_next.last  = in_data.last_in;
        tag1_next.gt    = !d1_next[W] && (d1_next != '0);
    end

    // leading one of the positive difference
    always_comb begin
        p2_next = '0;
        for (int i = 0; i < W; i++) begin
            if (d1_reg[i]) begin
                p2_next = llr_pkg::POS_W'(i);
            end
        end
    end

    always_comb begin
        lin_prod = (2*W+1)'(linear_gain) * (2*W+1)'(xm1_reg);
        bt2_next = lin_prod[2*W:llr_pkg::FRAC_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
        end else if (ce) begin
            tag1_reg <= tag1_next;
            tag2_reg <= tag1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            d1_reg  <= d1_next;
            xm1_reg <= xm1_next;
            d2_reg  <= d1_reg[W-1:0];
            p2_reg  <= p2_next;
            bt2_reg <= bt2_next;
        end
    end

    assign tag_o = tag2_reg;
    assign d_o   = d2_reg;
    assign p_o   = p2_reg;
    assign bt_o  = bt2_reg;

endmodule

`default_nettype wire

/* rtl/core/llr_log.sv */
// llr_log: natural log by normalising shift and interpolated table lookup
// stages three to five of the pipeline, linear term carried alongside
// depends on llr_pkg
`timescale 1ns / 1ps
`default_nettype none

module llr_log (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               ce,
    input  wire llr_pkg::tag_t                      tag_i,
    input  wire logic [llr_pkg::DATA_W-1:0]         d_i,
    input  wire logic [llr_pkg::POS_W-1:0]          p_i,
    input  wire logic signed [llr_pkg::BT_W-1:0]    bt_i,
    output llr_pkg::tag_t                           tag_o,
    output logic signed [llr_pkg::LN_W-1:0]         lnv_o,
    output logic signed [llr_pkg::BT_W-1:0]         bt_o
);

    localparam int W = llr_pkg::DATA_W;

    // stage three
    llr_pkg::tag_t                       tag3_reg;
    logic [llr_pkg::TAB_W-1:0]           tlo3_reg, tlo3_next;
    logic [llr_pkg::SLOPE_W-1:0]         slope3_reg, slope3_next;
    logic [llr_pkg::REM_W-1:0]           rem3_reg, rem3_next;
    logic signed [llr_pkg::LNP_W-1:0]    pl3_reg, pl3_next;
    logic signed [llr_pkg::BT_W-1:0]     bt3_reg;

    // stage four
    llr_pkg::tag_t                       tag4_reg;
    logic [llr_pkg::TAB_W-1:0]           tlo4_reg;
    logic [llr_pkg::PROD_W-1:0]          prod4_reg, prod4_next;
    logic signed [llr_pkg::LNP_W-1:0]    pl4_reg;
    logic signed [llr_pkg::BT_W-1:0]     bt4_reg;

    // stage five
    llr_pkg::tag_t                       tag5_reg;
    logic signed [llr_pkg::LN_W-1:0]     lnv5_reg, lnv5_next;
    logic signed [llr_pkg::BT_W-1:0]     bt5_reg;

    logic [W-1:0]                        norm;
    logic [llr_pkg::POS_W-1:0]           shamt;
    logic [llr_pkg::SEG_W-1:0]           seg;
    logic [llr_pkg::SEG_W:0]             seg_hi;
    logic [llr_pkg::TAB_W-1:0]           thi;
    logic signed [llr_pkg::EXP_W-1:0]    pe;
    logic signed [46:0]                  plx;
    logic signed [46:0]                  pl_shift;

    always_comb begin
        shamt       = llr_pkg::POS_W'(W - 1) - p_i;
        norm        = d_i << shamt;
        seg         = norm[W-2 -: llr_pkg::SEG_W];
        rem3_next   = norm[llr_pkg::REM_W-1:0];
        seg_hi      = {1'b0, seg} + (llr_pkg::SEG_W+1)'(1);
        tlo3_next   = llr_pkg::LN_TAB[{1'b0, seg}];
        thi         = llr_pkg::LN_TAB[seg_hi];
        slope3_next = llr_pkg::SLOPE_W'(thi - tlo3_next);
        // exponent part, floored to the output fraction
        pe          = $signed({2'b00, p_i}) - llr_pkg::EXP_W'(llr_pkg::FRAC_W);
        plx         = 47'(pe) * llr_pkg::LN2_Q40;
        pl_shift    = plx >>> 16;
        pl3_next    = pl_shift[llr_pkg::LNP_W-1:0];
    end

    always_comb begin
        prod4_next = llr_pkg::PROD_W'(slope3_reg) * llr_pkg::PROD_W'(rem3_reg);
    end

    always_comb begin
        lnv5_next = llr_pkg::LN_W'(pl4_reg)
                  + llr_pkg::LN_W'(tlo4_reg)
                  + llr_pkg::LN_W'(prod4_reg[llr_pkg::PROD_W-1:llr_pkg::REM_W]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag3_reg <= '0;
            tag4_reg <= '0;
            tag5_reg <= '0;
        end else if (ce) begin
            tag3_reg <= tag_i;
            tag4_reg <= tag3_reg;
            tag5_reg <= tag4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            tlo3_reg   <= tlo3_next;
            slope3_reg <= slope3_next;
            rem3_reg   <= rem3_next;
            pl3_reg    <= pl3_next;
            bt3_reg    <= bt_i;
            tlo4_reg   <= tlo3_reg;
            prod4_reg  <= prod4_next;
            pl4_reg    <= pl3_reg;
            bt4_reg    <= bt3_reg;
            lnv5_reg   <= lnv5_next;
            bt5_reg    <= bt4_reg;
        end
    end

    assign tag_o = tag5_reg;
    assign lnv_o = lnv5_reg;
    assign bt_o  = bt5_reg;

endmodule

`default_nettype wire

/* rtl/core/llr_back.sv */
// llr_back: log gain product, three-term sum and saturation to the output word
// stages six to eight of the pipeline, the last one being the output register
// depends on llr_pkg
`timescale 1ns / 1ps
`default_nettype none

module llr_back (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               ce,
    input  wire llr_pkg::tag_t                      tag_i,
    input  wire logic signed [llr_pkg::LN_W-1:0]    lnv_i,
    input  wire logic signed [llr_pkg::BT_W-1:0]    bt_i,
    input  wire logic signed [llr_pkg::DATA_W-1:0]  log_gain,
    input  wire logic signed [llr_pkg::DATA_W-1:0]  constant_term,
    output logic                                    out_valid,
    output llr_pkg::out_word_t                      out_data
);

    localparam int W  = llr_pkg::DATA_W;
    localparam int SW = llr_pkg::SUM_W;
    localparam int PW = W + llr_pkg::LN_W;

    localparam logic signed [SW-1:0] SUM_ONE = SW'(1) <<< llr_pkg::FRAC_W;
    localparam logic signed [SW-1:0] SUM_MAX = (SW'(1) <<< (W - 1)) - SW'(1);
    localparam logic signed [SW-1:0] SUM_MIN = -(SW'(1) <<< (W - 1));

    // stage six
    llr_pkg::tag_t                    tag6_reg;
    logic signed [llr_pkg::LT_W-1:0]  lt6_reg, lt6_next;
    logic signed [llr_pkg::BT_W-1:0]  bt6_reg;
    logic signed [PW-1:0]             log_prod;

    // stage seven
    llr_pkg::tag_t                    tag7_reg;
    logic signed [SW-1:0]             sum7_reg, sum7_next;

    // stage eight
    logic                             valid8_reg;
    llr_pkg::out_word_t               out8_reg, out8_next;

    always_comb begin
        log_prod = PW'(log_gain) * PW'(lnv_i);
        lt6_next = log_prod[PW-1:llr_pkg::FRAC_W];
    end

    always_comb begin
        if (tag6_reg.gt) begin
            sum7_next = SW'(lt6_reg) + SW'(bt6_reg) + SW'(constant_term);
        end else begin
            sum7_next = SUM_ONE;
        end
    end

    always_comb begin
        out8_next.last_out = tag7_reg.last;
        if (sum7_reg > SUM_MAX) begin
            out8_next.flux = SUM_MAX[W-1:0];
        end else if (sum7_reg < SUM_MIN) begin
            out8_next.flux = SUM_MIN[W-1:0];
        end else begin
            out8_next.flux = sum7_reg[W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag6_reg   <= '0;
            tag7_reg   <= '0;
            valid8_reg <= 1'b0;
        end else if (ce) begin
            tag6_reg   <= tag_i;
            tag7_reg   <= tag6_reg;
            valid8_reg <= tag7_reg.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            lt6_reg  <= lt6_next;
            bt6_reg  <= bt_i;
            sum7_reg <= sum7_next;
            out8_reg <= out8_next;
        end
    end

    assign out_valid = valid8_reg;
    assign out_data  = out8_reg;

endmodule

`default_nettype wire

/* tb/tb_log_linear_ramp_model.sv */
// tb_log_linear_ramp_model: self-checking bench for the log-linear ramp evaluator
// drives random sample words and coefficient sets, predicts each flux word in a scoreboard
// depends on llr_pkg and log_linear_ramp_model
`timescale 1ns / 1ps

module tb_log_linear_ramp_model;
    import llr_pkg::*;

    localparam int NUM_COEFS       = 5;
    localparam int IDLE_PCT        = 11;
    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int TAIL_CYCLES     = 16;
    localparam int STALL_LIMIT     = 4000;

    localparam int NORM_POS = 40;
    localparam int SEG_BITS = 36;
    localparam longint LN2_Q40 = 64'sd762123384785;
    localparam longint SAT_HI  = (longint'(1) <<< (DATA_W - 1)) - 1;
    localparam longint SAT_LO  = -SAT_HI - 1;

    localparam logic [DATA_W-1:0] Q_ONE     = 1 << FRAC_W;
    localparam logic [DATA_W-1:0] Q_HALF    = 1 << (FRAC_W - 1);
    localparam logic [DATA_W-1:0] Q_QUARTER = 1 << (FRAC_W - 2);
    localparam logic [DATA_W-1:0] Q_SEG     = 1 << (FRAC_W - 4);
    localparam logic [DATA_W-1:0] W_MAX     = {1'b0, {(DATA_W - 1){1'b1}}};
    localparam logic [DATA_W-1:0] W_MIN     = {1'b1, {(DATA_W - 1){1'b0}}};

    // ln(1 + k/16), k = 0..16, Q0.24
    localparam longint LN_SEG [0:16] = '{
        0, 1017112, 1976071, 2883169, 3743728, 4562291, 5342767, 6088544, 6802576,
        7487455, 8145469, 8778647, 9388795, 9977530, 10546303, 11096425, 11629080
    };

    class ramp_scoreboard;
        logic signed [DATA_W-1:0] coef [NUM_COEFS];
        out_word_t flux_due_q [$];
        int errors;

        function new();
            foreach (coef[i]) coef[i] = '0;
            errors = 0;
        endfunction

        function void set_coef(int idx, logic [DATA_W-1:0] v);
            if (idx < NUM_COEFS) begin
                coef[idx] = v;
            end
        endfunction

        function int pending();
            return flux_due_q.size();
        endfunction

        function longint natural_log_q(logic [63:0] d);
            int p;
            int k;
            logic [63:0] n, f, r, rise;
            longint m, l;
            p = DATA_W;
            while (p > 0 && d[p] == 1'b0) p--;
            n = d << (NORM_POS - p);
            f = n - (64'd1 << NORM_POS);
            k = int'(f[NORM_POS-1:SEG_BITS]);
            r = f & ((64'd1 << SEG_BITS) - 64'd1);
            rise = 64'(LN_SEG[k + 1] - LN_SEG[k]);
            m = LN_SEG[k] + longint'((rise * r) >> SEG_BITS);
            l = longint'(p - FRAC_W) * LN2_Q40 + m * 64'sd65536;
            return l >>> (NORM_POS - FRAC_W);
        endfunction

        function logic [DATA_W-1:0] model_flux(logic signed [DATA_W-1:0] xw);
            longint xs, x0, a, b, c, x1, y;
            xs = longint'(xw);
            x0 = longint'(coef[REG_LOG_OFFSET]);
            a  = longint'(coef[REG_LOG_GAIN]);
            b  = longint'(coef[REG_LINEAR_GAIN]);
            c  = longint'(coef[REG_CONSTANT_TERM]);
            x1 = longint'(coef[REG_LINEAR_OFFSET]);
            if (xs > x0) begin
                y = ((a * natural_log_q(64'(xs - x0))) >>> FRAC_W)
                  + ((b * (xs - x1)) >>> FRAC_W) + c;
            end else begin
                y = longint'(1) <<< FRAC_W;
            end
            if (y > SAT_HI) y = SAT_HI;
            if (y < SAT_LO) y = SAT_LO;
            return y[DATA_W-1:0];
        endfunction

        function void note_sample(in_word_t w);
            out_word_t want;
            want.flux     = model_flux(w.sample_x);
            want.last_out = w.last_in;
            flux_due_q.push_back(want);
        endfunction

        function void check_result(out_word_t got);
            out_word_t want;
            if (flux_due_q.size() == 0) begin
                $error("unexpected word: flux %0d last_out %0b", got.flux, got.last_out);
                errors++;
                return;
            end
            want = flux_due_q.pop_front();
            if (got.flux !== want.flux) begin
                $error("flux: expected %0d, actual %0d", want.flux, got.flux);
                errors++;
            end
            if (got.last_out !== want.last_out) begin
                $error("last_out: expected %0b, actual %0b", want.last_out, got.last_out);
                errors++;
            end
        endfunction
    endclass

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                s_valid   = 1'b0;
    logic                s_ready;
    in_word_t            s_data    = '0;
    logic                m_valid;
    logic                m_ready   = 1'b0;
    out_word_t           m_data;
    logic                cfg_we    = 1'b0;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [DATA_W-1:0]   cfg_wdata = '0;
    bit                  steady    = 1'b0;

    ramp_scoreboard board = new();

    log_linear_ramp_model u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // result side: check accepted words, stall at random unless steady is set
    initial begin
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                board.check_result(m_data);
            end
            m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // ends the run if neither channel moves for too long
    initial begin
        int quiet;
        quiet = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb_log_linear_ramp_model: FAIL");
        $finish;
    end

    task automatic send_sample(input logic [DATA_W-1:0] x, input logic last);
        in_word_t w;
        w.sample_x = x;
        w.last_in  = last;
        if (!steady) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        board.note_sample(w);
    endtask

    task automatic drain_pipe();
        s_valid <= 1'b0;
        do @(posedge aclk); while (board.pending() != 0);
    endtask

    task automatic write_reg(input int idx, input logic [DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx[IDX_W-1:0];
        cfg_wdata <= v;
        @(posedge aclk);
        board.set_coef(idx, v);
    endtask

    // one unused index is written as well and must change nothing
    task automatic load_coefs(input logic [DATA_W-1:0] x0, input logic [DATA_W-1:0] a,
                              input logic [DATA_W-1:0] b, input logic [DATA_W-1:0] c,
                              input logic [DATA_W-1:0] x1);
        write_reg(REG_LOG_OFFSET, x0);
        write_reg(REG_LOG_GAIN, a);
        write_reg(REG_LINEAR_GAIN, b);
        write_reg(REG_CONSTANT_TERM, c);
        write_reg(REG_LINEAR_OFFSET, x1);
        write_reg($urandom_range(NUM_COEFS, (1 << IDX_W) - 1), $urandom());
        cfg_we <= 1'b0;
    endtask

    function automatic logic [DATA_W-1:0] pick_coef();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: begin
                case ($urandom_range(0, 4))
                    0: return W_MAX;
                    1: return W_MIN;
                    2: return '0;
                    3: return Q_ONE;
                    default: return -Q_ONE;
                endcase
            end
            default: return int'($urandom_range(0, 1 << 27)) - (1 << 26);
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_sample(logic signed [DATA_W-1:0] x0);
        longint xv;
        case ($urandom_range(0, 9))
            0, 1: return $urandom();
            2: xv = longint'(x0) - longint'($urandom_range(0, 1 << 20));
            default: begin
                xv = longint'(x0) + 1
                   + (longint'({32'b0, $urandom()}) >> $urandom_range(0, 31));
            end
        endcase
        if (xv > SAT_HI || xv < SAT_LO) begin
            return $urandom();
        end
        return xv[DATA_W-1:0];
    endfunction

    initial begin
        logic [DATA_W-1:0] set [NUM_COEFS];
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: offset edges, tiny and huge distances, every table segment
        load_coefs('0, Q_ONE, Q_HALF, Q_QUARTER, Q_ONE);
        send_sample('0, 1'b0);
        send_sample('1, 1'b1);
        send_sample(W_MIN, 1'b0);
        send_sample(1, 1'b1);
        send_sample(W_MAX, 1'b0);
        for (int k = 0; k < 16; k++) begin
            send_sample(Q_ONE + k * Q_SEG, k[0]);
        end

        // saturation both ways
        drain_pipe();
        load_coefs(W_MIN, W_MAX, W_MAX, W_MAX, W_MIN);
        send_sample(W_MAX, 1'b1);
        send_sample(W_MIN, 1'b0);
        drain_pipe();
        load_coefs(W_MIN, W_MAX, W_MAX, W_MIN, W_MAX);
        send_sample(W_MIN + 1, 1'b0);
        send_sample('0, 1'b1);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_pipe();
            foreach (set[i]) begin
                case (ph)
                    0: set[i] = '0;
                    1: set[i] = W_MAX;
                    2: set[i] = W_MIN;
                    default: set[i] = pick_coef();
                endcase
            end
            load_coefs(set[REG_LOG_OFFSET], set[REG_LOG_GAIN], set[REG_LINEAR_GAIN],
                       set[REG_CONSTANT_TERM], set[REG_LINEAR_OFFSET]);
            steady = (ph == 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 4 && n == ITEMS_PER_PHASE / 2) begin
                    drain_pipe();
                end
                send_sample(pick_sample(board.coef[REG_LOG_OFFSET]),
                            $urandom_range(0, 7) == 0);
            end
        end
        steady = 1'b0;

        drain_pipe();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("tb_log_linear_ramp_model: PASS");
        end else begin
            $display("tb_log_linear_ramp_model: FAIL");
        end
        $finish;
    end

endmodule

/* log_linear_ramp_model.f */
rtl/core/llr_pkg.sv
rtl/core/llr_front.sv
rtl/core/llr_log.sv
rtl/core/llr_back.sv
rtl/core/log_linear_ramp_model.sv
tb/tb_log_linear_ramp_model.sv
